// ===== src/dsbf_pkg.sv =====
package dsbf_pkg;

  // line control characters
  localparam logic [7:0] SYM_DLE = 8'h10;
  localparam logic [7:0] SYM_STX = 8'h02;
  localparam logic [7:0] SYM_ETX = 8'h03;

  // command queue depth and pointer width
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = 1;
  localparam int unsigned QCNT_W      = 2;

  // one classified payload byte, as handed from front to back
  typedef struct packed {
    logic [7:0] data;
    logic       open_frame;
    logic       stuff;
    logic       close_frame;
    logic [7:0] bcc;
  } cmd_t;

  // emit sequencer phases
  typedef enum logic [2:0] {
    PH_START,
    PH_HDR_DLE,
    PH_HDR_STX,
    PH_STUFF_DLE,
    PH_DATA,
    PH_TRL_DLE,
    PH_TRL_ETX,
    PH_BCC
  } phase_t;

endpackage

// ===== src/dsbf_front.sv =====
module dsbf_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_ready,
  input  logic [7:0]        in_payload_byte,
  input  logic              in_frame_last,
  output logic              push,
  output dsbf_pkg::cmd_t    push_cmd
);

  logic       inside_frame_r, inside_frame_nxt;
  logic [7:0] check_accum_r, check_accum_nxt;
  logic [7:0] accum_new;

  assign push = in_valid && in_ready;

  // classify the byte and fold it into the running check
  always_comb begin
    accum_new = (inside_frame_r ? check_accum_r : 8'h00) ^ in_payload_byte;
    push_cmd.data        = in_payload_byte;
    push_cmd.open_frame  = !inside_frame_r;
    push_cmd.stuff       = (in_payload_byte == dsbf_pkg::SYM_DLE);
    push_cmd.close_frame = in_frame_last;
    push_cmd.bcc         = accum_new ^ dsbf_pkg::SYM_ETX;
    inside_frame_nxt     = inside_frame_r;
    check_accum_nxt      = check_accum_r;
    if (push) begin
      inside_frame_nxt = !in_frame_last;
      check_accum_nxt  = in_frame_last ? 8'h00 : accum_new;
    end
  end

  // frame state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inside_frame_r <= 1'b0;
      check_accum_r  <= 8'h00;
    end else begin
      inside_frame_r <= inside_frame_nxt;
      check_accum_r  <= check_accum_nxt;
    end
  end

endmodule

// ===== src/dsbf_queue.sv =====
module dsbf_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  dsbf_pkg::cmd_t    push_cmd,
  output logic              full,
  input  logic              pop,
  output logic              head_valid,
  output dsbf_pkg::cmd_t    head_cmd
);

  dsbf_pkg::cmd_t                      entry_r [dsbf_pkg::QUEUE_DEPTH];
  logic [dsbf_pkg::QPTR_W-1:0]         wr_ptr_r, rd_ptr_r;
  logic [dsbf_pkg::QCNT_W-1:0]         count_r, count_nxt;

  assign full       = (count_r == dsbf_pkg::QCNT_W'(dsbf_pkg::QUEUE_DEPTH));
  assign head_valid = (count_r != '0);
  assign head_cmd   = entry_r[rd_ptr_r];

  // occupancy
  always_comb begin
    count_nxt = count_r;
    if (push && !pop) count_nxt = count_r + 1'b1;
    if (pop && !push) count_nxt = count_r - 1'b1;
  end

  // pointers and count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      count_r <= count_nxt;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) entry_r[wr_ptr_r] <= push_cmd;
  end

endmodule

// ===== src/dsbf_back.sv =====
module dsbf_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              head_valid,
  input  dsbf_pkg::cmd_t    head_cmd,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [7:0]        out_line_byte,
  output logic              out_run_end
);

  dsbf_pkg::phase_t phase_r, phase_nxt, cur_phase;
  logic             out_valid_r, out_valid_nxt;
  logic [7:0]       out_byte_r, out_byte_nxt;
  logic             out_end_r, out_end_nxt;
  logic             load;
  logic             final_byte;

  assign out_valid     = out_valid_r;
  assign out_line_byte = out_byte_r;
  assign out_run_end   = out_end_r;

  // next line byte, phase advance and queue pop
  always_comb begin
    load = head_valid && (!out_valid_r || out_ready);
    if (phase_r == dsbf_pkg::PH_START) begin
      if (head_cmd.open_frame)  cur_phase = dsbf_pkg::PH_HDR_DLE;
      else if (head_cmd.stuff)  cur_phase = dsbf_pkg::PH_STUFF_DLE;
      else                      cur_phase = dsbf_pkg::PH_DATA;
    end else begin
      cur_phase = phase_r;
    end

    final_byte = 1'b0;
    phase_nxt  = cur_phase;
    case (cur_phase)
      dsbf_pkg::PH_HDR_DLE: begin
        out_byte_nxt = dsbf_pkg::SYM_DLE;
        phase_nxt    = dsbf_pkg::PH_HDR_STX;
      end
      dsbf_pkg::PH_HDR_STX: begin
        out_byte_nxt = dsbf_pkg::SYM_STX;
        phase_nxt    = head_cmd.stuff ? dsbf_pkg::PH_STUFF_DLE : dsbf_pkg::PH_DATA;
      end
      dsbf_pkg::PH_STUFF_DLE: begin
        out_byte_nxt = dsbf_pkg::SYM_DLE;
        phase_nxt    = dsbf_pkg::PH_DATA;
      end
      dsbf_pkg::PH_DATA: begin
        out_byte_nxt = head_cmd.data;
        if (head_cmd.close_frame) begin
          phase_nxt = dsbf_pkg::PH_TRL_DLE;
        end else begin
          final_byte = 1'b1;
          phase_nxt  = dsbf_pkg::PH_START;
        end
      end
      dsbf_pkg::PH_TRL_DLE: begin
        out_byte_nxt = dsbf_pkg::SYM_DLE;
        phase_nxt    = dsbf_pkg::PH_TRL_ETX;
      end
      dsbf_pkg::PH_TRL_ETX: begin
        out_byte_nxt = dsbf_pkg::SYM_ETX;
        phase_nxt    = dsbf_pkg::PH_BCC;
      end
      dsbf_pkg::PH_BCC: begin
        out_byte_nxt = head_cmd.bcc;
        final_byte   = 1'b1;
        phase_nxt    = dsbf_pkg::PH_START;
      end
      default: begin
        out_byte_nxt = head_cmd.data;
        phase_nxt    = dsbf_pkg::PH_START;
      end
    endcase

    out_end_nxt = final_byte;
    pop         = load && final_byte;
    if (!load) begin
      phase_nxt    = phase_r;
      out_byte_nxt = out_byte_r;
      out_end_nxt  = out_end_r;
    end
    out_valid_nxt = load || (out_valid_r && !out_ready);
  end

  // sequencer state and output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= dsbf_pkg::PH_START;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    out_byte_r <= out_byte_nxt;
    out_end_r  <= out_end_nxt;
  end

endmodule

// ===== src/dle_stuffing_bcc_framer.sv =====
// path: each item is registered in the queue, then each byte in out_byte_r
// throughput: one line byte per cycle unless stalled by out_ready; 1 to 7 bytes
// per item (header 2, stuffed dle 1, payload 1, trailer 3), by the sequencer
// a 2-entry command queue lets input transfers continue while the output stalls
// reset: synchronous active-low rst_n closes any open frame, clears the check
// byte, empties the queue and drops out_valid
module dle_stuffing_bcc_framer (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_payload_byte,
  input  logic       in_frame_last,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_line_byte,
  output logic       out_run_end
);

  dsbf_pkg::cmd_t push_cmd, head_cmd;
  logic           push, pop, full, head_valid;

  assign in_ready = !full;

  // classify bytes and track frame state
  dsbf_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_payload_byte (in_payload_byte),
    .in_frame_last   (in_frame_last),
    .push            (push),
    .push_cmd        (push_cmd)
  );

  // command queue between front and back
  dsbf_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_cmd   (push_cmd),
    .full       (full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_cmd   (head_cmd)
  );

  // emit line bytes
  dsbf_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .head_valid    (head_valid),
    .head_cmd      (head_cmd),
    .pop           (pop),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_line_byte (out_line_byte),
    .out_run_end   (out_run_end)
  );

endmodule
